@@ hw/rtl/wess_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wess_pkg
// Shared types and constants of the weighted error syndrome sampler: item
// layouts of both channels, the stored event entry, register and opcode codes.
// ----------------------------------------------------------------------------
package wess_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_EVENTS_DEF      = 1024;
    localparam int SYNDROME_BITS_DEF   = 512;
    localparam int MAX_OBSERVABLES_DEF = 8;

    // fixed field widths
    localparam int DET_W      = 9;
    localparam int OBS_MASK_W = 8;
    localparam int CUM_W      = 32;
    localparam int WORD_W     = 64;
    localparam int WIDX_W     = 3;
    localparam int EPOCH_W    = 8;

    // configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    localparam int EV_CFG_W  = 11;
    localparam int ERR_CFG_W = 7;
    localparam int DET_CFG_W = 9;

    localparam logic [1:0] REG_EVENTS    = 2'd0;
    localparam logic [1:0] REG_ERRORS    = 2'd1;
    localparam logic [1:0] REG_DETECTORS = 2'd2;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // input item
    typedef struct packed {
        logic                  opcode;
        logic [9:0]            event_index;
        logic [DET_W-1:0]      detector_a;
        logic [DET_W-1:0]      detector_b;
        logic                  a_is_boundary;
        logic                  b_is_boundary;
        logic [OBS_MASK_W-1:0] observable_mask;
        logic [CUM_W-1:0]      cumulative_threshold;
        logic [CUM_W-1:0]      draw_value;
    } cmd_item_t;

    // result item
    typedef struct packed {
        logic [WORD_W-1:0] syndrome_word;
        logic [WIDX_W-1:0] word_index;
        logic              last_word;
    } word_item_t;

    // one event table entry as stored in memory
    typedef struct packed {
        logic [DET_W-1:0]      detector_a;
        logic [DET_W-1:0]      detector_b;
        logic                  a_is_boundary;
        logic                  b_is_boundary;
        logic [OBS_MASK_W-1:0] observable_mask;
        logic [CUM_W-1:0]      cumulative_threshold;
    } event_entry_t;

endpackage

@@ hw/rtl/wess_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wess_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module wess_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/weighted_error_syndrome_sampler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_error_syndrome_sampler_top
// Draws error events from a sorted cumulative table without replacement and
// emits the resulting detector and observable syndrome as 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): opcode load writes one
//   table entry, opcode draw picks the first entry in use with a cumulative
//   value at least the draw, else the last. An entry already picked in this
//   shot is skipped, otherwise its detector and observable bits are toggled.
//   word channel (word_valid / word_stall / word): once errors_per_shot
//   distinct events are in, ceil((detectors_in_use + MAX_OBSERVABLES) / 64)
//   words (at most 8) come out in order, the last one flagged.
//   A draw runs a binary search over the n events in use, each step
//   a read of the event table memory, then one read-modify-write step.
//   The finishing draw then hands out the words while the word channel
//   is free; a stall holds the word register and the emit sequence.
//   The next item is taken while the last word still waits in its register.
//   Picked entries carry an 8-bit shot tag in the mark memory. After reset,
//   and once every 255 shots when the tag wraps, a clearing pass rewrites
//   every entry of the mark memory; item_stall is high meanwhile and
//   configuration writes are taken as usual.
// ----------------------------------------------------------------------------
module weighted_error_syndrome_sampler_top
    import wess_pkg::*;
#(
    parameter int MAX_EVENTS      = MAX_EVENTS_DEF,
    parameter int SYNDROME_BITS   = SYNDROME_BITS_DEF,
    parameter int MAX_OBSERVABLES = MAX_OBSERVABLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // item channel
    input  logic              item_valid,
    output logic              item_stall,
    input  cmd_item_t         item,
    // word channel
    output logic              word_valid,
    input  logic              word_stall,
    output word_item_t        word,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int EV_AW     = $clog2(MAX_EVENTS);
    localparam int CW        = $clog2(MAX_EVENTS + 1);
    localparam int SYN_WORDS = (SYNDROME_BITS + 63) / 64;
    localparam int SYN_W     = SYN_WORDS * WORD_W;
    localparam int WORD_CAP  = (SYN_WORDS < 8) ? SYN_WORDS : 8;
    localparam int OBS_N     = (MAX_OBSERVABLES < OBS_MASK_W) ? MAX_OBSERVABLES : OBS_MASK_W;
    localparam int ENTRY_W   = $bits(event_entry_t);
    localparam logic [OBS_MASK_W-1:0] OBS_KEEP  = OBS_MASK_W'((1 << OBS_N) - 1);
    localparam logic [EV_AW-1:0]      LAST_SLOT = EV_AW'(MAX_EVENTS - 1);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_SEARCH,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [EV_CFG_W-1:0]    events_reg;
    logic [ERR_CFG_W-1:0]   errors_reg;
    logic [DET_CFG_W-1:0]   dets_reg;
    logic [EV_AW-1:0]       sweep_idx_reg;
    logic [EPOCH_W-1:0]     epoch_reg;
    logic [ERR_CFG_W-1:0]   accepted_reg;
    logic [SYN_W-1:0]       syn_reg;
    logic [CW-1:0]          lo_reg;
    logic [CW-1:0]          hi_reg;
    logic [CW-1:0]          n_reg;
    logic [EV_AW-1:0]       mid_reg;
    logic [EV_AW-1:0]       pick_reg;
    logic [CUM_W-1:0]       draw_reg;
    logic [WIDX_W-1:0]      widx_reg;
    logic                   word_valid_reg;
    word_item_t             word_reg;

    logic                   cfg_write;
    logic [CW-1:0]          n_eff;
    logic [ERR_CFG_W-1:0]   k_eff;
    logic [EV_AW-1:0]       mid_first;
    logic                   take_item;
    logic                   load_ok;

    logic                   table_we;
    logic [EV_AW-1:0]       table_addr;
    logic [ENTRY_W-1:0]     table_rdata;
    event_entry_t           load_entry;
    event_entry_t           rd_entry;
    logic                   marks_we;
    logic [EV_AW-1:0]       marks_addr;
    logic [EPOCH_W-1:0]     marks_wdata;
    logic [EPOCH_W-1:0]     marks_rdata;

    logic                   ge;
    logic [CW-1:0]          mid_ext;
    logic [CW-1:0]          lo_next;
    logic [CW-1:0]          hi_next;
    logic [CW:0]            mid_sum;
    logic [EV_AW-1:0]       mid_next;
    logic                   search_done;
    logic [EV_AW-1:0]       pick;
    logic                   marked;
    logic [ERR_CFG_W-1:0]   count_inc;
    logic                   shot_done;

    logic [SYNDROME_BITS-1:0] obs_vec;
    logic [SYNDROME_BITS-1:0] tog;
    logic [11:0]            word_total;
    logic [5:0]             word_count;
    logic [5:0]             nw;
    logic [WIDX_W-1:0]      last_idx;
    logic                   word_free;

    // configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            events_reg <= EV_CFG_W'(1);
            errors_reg <= ERR_CFG_W'(1);
            dets_reg   <= DET_CFG_W'(504);
        end
        else if (cfg_write)
        begin
            case (paddr[CFG_AW-1:2])
                REG_EVENTS:    events_reg <= pwdata[EV_CFG_W-1:0];
                REG_ERRORS:    errors_reg <= pwdata[ERR_CFG_W-1:0];
                REG_DETECTORS: dets_reg   <= pwdata[DET_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[CFG_AW-1:2])
            REG_EVENTS:    prdata = CFG_DW'(events_reg);
            REG_ERRORS:    prdata = CFG_DW'(errors_reg);
            REG_DETECTORS: prdata = CFG_DW'(dets_reg);
            default:       prdata = '0;
        endcase
    end

    // effective event count and shot size
    always_comb
    begin
        if (events_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(events_reg) > 32'(MAX_EVENTS))
        begin
            n_eff = CW'(MAX_EVENTS);
        end
        else
        begin
            n_eff = CW'(events_reg);
        end
    end

    assign k_eff     = (errors_reg == '0) ? ERR_CFG_W'(1) : errors_reg;
    assign mid_first = EV_AW'(n_eff >> 1);

    // item handshake
    assign item_stall = (state_reg != ST_IDLE);
    assign take_item  = item_valid && !item_stall;
    assign load_ok    = take_item && (item.opcode == OP_LOAD)
                        && (32'(item.event_index) < 32'(MAX_EVENTS));

    // entry written by a load
    always_comb
    begin
        load_entry.detector_a           = item.detector_a;
        load_entry.detector_b           = item.detector_b;
        load_entry.a_is_boundary        = item.a_is_boundary;
        load_entry.b_is_boundary        = item.b_is_boundary;
        load_entry.observable_mask      = item.observable_mask;
        load_entry.cumulative_threshold = item.cumulative_threshold;
    end

    assign rd_entry = event_entry_t'(table_rdata);

    // one binary search step on the entry read last cycle
    assign ge          = (rd_entry.cumulative_threshold >= draw_reg);
    assign mid_ext     = CW'(mid_reg);
    assign lo_next     = ge ? lo_reg : (mid_ext + CW'(1));
    assign hi_next     = ge ? mid_ext : hi_reg;
    assign mid_sum     = {1'b0, lo_next} + {1'b0, hi_next};
    assign mid_next    = EV_AW'(mid_sum >> 1);
    assign search_done = !(lo_next < hi_next);
    assign pick        = (lo_next == n_reg) ? EV_AW'(n_reg - CW'(1)) : EV_AW'(lo_next);

    // event table address and write
    always_comb
    begin
        table_we   = load_ok;
        table_addr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item.opcode == OP_LOAD)
                begin
                    table_addr = EV_AW'(item.event_index);
                end
                else
                begin
                    table_addr = mid_first;
                end
            end
            ST_SEARCH:  table_addr = search_done ? pick : mid_next;
            default:    table_addr = '0;
        endcase
    end

    wess_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_EVENTS)
    ) u_table_ram (
        .clk   (clk),
        .we    (table_we),
        .addr  (table_addr),
        .wdata (load_entry),
        .rdata (table_rdata)
    );

    // mark memory: an entry is picked when it holds the current shot tag
    assign marked = (marks_rdata == epoch_reg);

    always_comb
    begin
        marks_we    = 1'b0;
        marks_addr  = '0;
        marks_wdata = epoch_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                marks_we    = 1'b1;
                marks_addr  = sweep_idx_reg;
                marks_wdata = '0;
            end
            ST_SEARCH:  marks_addr = pick;
            ST_FETCH:
            begin
                marks_we   = !marked;
                marks_addr = pick_reg;
            end
            default:    marks_addr = '0;
        endcase
    end

    wess_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAX_EVENTS)
    ) u_marks_ram (
        .clk   (clk),
        .we    (marks_we),
        .addr  (marks_addr),
        .wdata (marks_wdata),
        .rdata (marks_rdata)
    );

    // toggle pattern of the fetched event, bits beyond the syndrome dropped
    assign obs_vec = SYNDROME_BITS'(rd_entry.observable_mask & OBS_KEEP) << dets_reg;

    for (genvar p = 0; p < SYNDROME_BITS; p++)
    begin : g_tog
        assign tog[p] = (!rd_entry.a_is_boundary && (32'(rd_entry.detector_a) == 32'(p)))
                      ^ (!rd_entry.b_is_boundary && (32'(rd_entry.detector_b) == 32'(p)))
                      ^ obs_vec[p];
    end

    assign count_inc = accepted_reg + ERR_CFG_W'(1);
    assign shot_done = (count_inc >= k_eff);

    // number of words in a finished syndrome
    assign word_total = 12'(dets_reg) + 12'(MAX_OBSERVABLES) + 12'd63;
    assign word_count = word_total[11:6];

    always_comb
    begin
        if (word_count > 6'(WORD_CAP))
        begin
            nw = 6'(WORD_CAP);
        end
        else if (word_count == '0)
        begin
            nw = 6'd1;
        end
        else
        begin
            nw = word_count;
        end
    end

    assign last_idx  = WIDX_W'(nw - 6'd1);
    assign word_free = !word_valid_reg || !word_stall;

    // sequencer, syndrome and word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_idx_reg  <= '0;
            epoch_reg      <= EPOCH_W'(1);
            accepted_reg   <= '0;
            syn_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            n_reg          <= '0;
            mid_reg        <= '0;
            pick_reg       <= '0;
            draw_reg       <= '0;
            widx_reg       <= '0;
            word_valid_reg <= 1'b0;
            word_reg       <= '0;
        end
        else
        begin
            // word taken outside the emit sequence
            if (word_valid_reg && !word_stall && (state_reg != ST_EMIT))
            begin
                word_valid_reg <= 1'b0;
            end

            case (state_reg)
                // clear the mark memory one entry a cycle
                ST_SWEEP:
                begin
                    if (sweep_idx_reg == LAST_SLOT)
                    begin
                        sweep_idx_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        sweep_idx_reg <= sweep_idx_reg + EV_AW'(1);
                    end
                end

                // take a draw and start the search over all events in use
                ST_IDLE:
                begin
                    if (take_item && (item.opcode == OP_DRAW))
                    begin
                        draw_reg  <= item.draw_value;
                        n_reg     <= n_eff;
                        lo_reg    <= '0;
                        hi_reg    <= n_eff;
                        mid_reg   <= mid_first;
                        state_reg <= ST_SEARCH;
                    end
                end

                // narrow the range until the first entry at or above the draw
                ST_SEARCH:
                begin
                    if (search_done)
                    begin
                        pick_reg  <= pick;
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        lo_reg  <= lo_next;
                        hi_reg  <= hi_next;
                        mid_reg <= mid_next;
                    end
                end

                // apply the picked event unless already taken this shot
                ST_FETCH:
                begin
                    if (marked)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        syn_reg      <= syn_reg ^ SYN_W'(tog);
                        accepted_reg <= count_inc;
                        widx_reg     <= '0;
                        state_reg    <= shot_done ? ST_EMIT : ST_IDLE;
                    end
                end

                // hand out the syndrome words, then start a new shot
                ST_EMIT:
                begin
                    if (word_free)
                    begin
                        word_valid_reg         <= 1'b1;
                        word_reg.syndrome_word <= syn_reg[{widx_reg, 6'b0} +: WORD_W];
                        word_reg.word_index    <= widx_reg;
                        word_reg.last_word     <= (widx_reg == last_idx);
                        widx_reg               <= widx_reg + WIDX_W'(1);
                        if (widx_reg == last_idx)
                        begin
                            syn_reg      <= '0;
                            accepted_reg <= '0;
                            if (epoch_reg == '1)
                            begin
                                epoch_reg <= EPOCH_W'(1);
                                state_reg <= ST_SWEEP;
                            end
                            else
                            begin
                                epoch_reg <= epoch_reg + EPOCH_W'(1);
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;

endmodule
